// ----- design/jrl_pkg.sv -----
// shared types, codes and constants of the job record list
package jrl_pkg;

    localparam int unsigned DEPTH_DEF = 16;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADPOS   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  position;
        logic [7:0]  job_id;
        logic [7:0]  memory_size;
        logic [15:0] arrival_time;
        logic [15:0] run_time;
        logic [15:0] deadline;
        logic [15:0] start_time;
        logic [15:0] memory_address;
        logic [7:0]  process_id;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  found_job_id;
        logic [7:0]  found_memory_size;
        logic [15:0] found_arrival_time;
        logic [15:0] found_run_time;
        logic [15:0] found_deadline;
        logic [15:0] found_start_time;
        logic [15:0] found_memory_address;
        logic [7:0]  found_process_id;
        logic [4:0]  entries_held;
    } t_rsp;

    // one stored job record
    typedef struct packed {
        logic [7:0]  job_id;
        logic [7:0]  memory_size;
        logic [15:0] arrival_time;
        logic [15:0] run_time;
        logic [15:0] deadline;
        logic [15:0] start_time;
        logic [15:0] memory_address;
        logic [7:0]  process_id;
    } t_rec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DEL_WR
    } t_state;

endpackage

// ----- design/jrl_mem.sv -----
// record store: one write port, one read port with registered read data
module jrl_mem #(
    parameter int unsigned DEPTH = jrl_pkg::DEPTH_DEF,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  jrl_pkg::t_rec  i_wdata,
    input  logic [AW-1:0]  i_raddr,
    output jrl_pkg::t_rec  o_rdata
);
    import jrl_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/job_record_list_insert_search_delete.sv -----
// top level of the job record list: command sequencer around the record store
//
// Records sit in one single-port-read memory with registered read data. Every
// record that is inspected or moved up passes through a read state and then a
// compare or write-back state, while a delete moves records down at one per cycle
// because the next read is issued alongside each write. An insert moves
// m = count - position + 1 records up before it writes the new record; a rejected
// insert or an unused command ends straight after decode. A search scans from
// slot 0 up to the first match or to the end of the list, and ends straight after
// decode on an empty list. A delete scans as the search does and then moves the
// records behind the match down.
// busy stays high from the accepting edge until the cycle in which o_done
// shows the result; o_done lasts one cycle and must be taken then.
module job_record_list_insert_search_delete #(
    parameter int unsigned DEPTH = jrl_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  jrl_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output jrl_pkg::t_rsp o_rsp
);
    import jrl_pkg::*;

    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = ((CW > 5) ? CW : 5) + 1;

    t_state         r_state, n_state;
    t_req           r_req, n_req;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_k, n_k;
    logic           r_done, n_done;
    t_rsp           r_rsp, n_rsp;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    t_rec           mem_wdata;
    logic [AW-1:0]  mem_raddr;
    t_rec           mem_rdata;

    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic            pos_ok;
    logic            is_full;
    logic [CW-1:0]   slot;
    logic [CW:0]     k_p1;
    logic [CW:0]     k_p2;
    logic [CW:0]     cnt_w;
    logic            match;
    t_rec            new_rec;

    jrl_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign pos_ext = CMPW'(r_req.position);
    assign cnt_ext = CMPW'(r_count);
    assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext + CMPW'(1));
    assign is_full = (r_count == CW'(DEPTH));
    assign slot    = CW'(pos_ext - CMPW'(1));
    assign k_p1    = {1'b0, r_k} + (CW+1)'(1);
    assign k_p2    = {1'b0, r_k} + (CW+1)'(2);
    assign cnt_w   = {1'b0, r_count};
    assign match   = (mem_rdata.job_id == r_req.job_id);
    assign busy    = (r_state != S_IDLE);

    assign new_rec = '{
        job_id:         r_req.job_id,
        memory_size:    r_req.memory_size,
        arrival_time:   r_req.arrival_time,
        run_time:       r_req.run_time,
        deadline:       r_req.deadline,
        start_time:     r_req.start_time,
        memory_address: r_req.memory_address,
        process_id:     r_req.process_id
    };

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (r_req.cmd == CMD_INSERT) begin
                    if (!pos_ok || is_full) begin
                        n_state = S_IDLE;
                    end else if (r_count == slot) begin
                        n_state = S_INS_PUT;
                    end else begin
                        n_state = S_INS_RD;
                    end
                end else if (r_req.cmd == CMD_SEARCH || r_req.cmd == CMD_DELETE) begin
                    n_state = (r_count == '0) ? S_IDLE : S_SCAN_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_INS_RD:  n_state = S_INS_WR;
            S_INS_WR:  n_state = (r_k - CW'(1) == slot) ? S_INS_PUT : S_INS_RD;
            S_INS_PUT: n_state = S_IDLE;
            S_SCAN_RD: n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                priority if (match) begin
                    if (r_req.cmd == CMD_DELETE && k_p1 < cnt_w) begin
                        n_state = S_DEL_WR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (k_p1 >= cnt_w) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            // the read of the next record was issued in the cycle before
            S_DEL_WR:  n_state = (k_p2 < cnt_w) ? S_DEL_WR : S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_req     = r_req;
        n_count   = r_count;
        n_k       = r_k;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_waddr = r_k[AW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = r_k[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                end
            end
            S_DECODE: begin
                n_rsp              = '0;
                n_rsp.entries_held = 5'(r_count);
                priority if (r_req.cmd == CMD_INSERT) begin
                    n_k = r_count;
                    if (!pos_ok) begin
                        n_rsp.status = ST_BADPOS;
                        n_done       = 1'b1;
                    end else if (is_full) begin
                        n_rsp.status = ST_FULL;
                        n_done       = 1'b1;
                    end
                end else if (r_req.cmd == CMD_SEARCH || r_req.cmd == CMD_DELETE) begin
                    n_k = '0;
                    if (r_count == '0) begin
                        n_rsp.status = ST_NOTFOUND;
                        n_done       = 1'b1;
                    end
                end else begin
                    n_rsp.status = ST_OK;
                    n_done       = 1'b1;
                end
            end
            S_INS_RD: begin
                mem_raddr = AW'(r_k - CW'(1));
            end
            S_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[AW-1:0];
                mem_wdata = mem_rdata;
                n_k       = r_k - CW'(1);
            end
            S_INS_PUT: begin
                mem_we             = 1'b1;
                mem_waddr          = slot[AW-1:0];
                mem_wdata          = new_rec;
                n_count            = r_count + CW'(1);
                n_rsp.status       = ST_OK;
                n_rsp.entries_held = 5'(r_count + CW'(1));
                n_done             = 1'b1;
            end
            S_SCAN_RD: begin
                mem_raddr = r_k[AW-1:0];
            end
            S_SCAN_CMP: begin
                // prefetch the record behind the current one for a delete
                mem_raddr = AW'(k_p1);
                priority if (match) begin
                    if (r_req.cmd == CMD_SEARCH) begin
                        n_rsp.status               = ST_OK;
                        n_rsp.found_job_id         = mem_rdata.job_id;
                        n_rsp.found_memory_size    = mem_rdata.memory_size;
                        n_rsp.found_arrival_time   = mem_rdata.arrival_time;
                        n_rsp.found_run_time       = mem_rdata.run_time;
                        n_rsp.found_deadline       = mem_rdata.deadline;
                        n_rsp.found_start_time     = mem_rdata.start_time;
                        n_rsp.found_memory_address = mem_rdata.memory_address;
                        n_rsp.found_process_id     = mem_rdata.process_id;
                        n_done                     = 1'b1;
                    end else if (k_p1 >= cnt_w) begin
                        n_count            = r_count - CW'(1);
                        n_rsp.status       = ST_OK;
                        n_rsp.entries_held = 5'(r_count - CW'(1));
                        n_done             = 1'b1;
                    end
                end else begin
                    n_k = CW'(k_p1);
                    if (k_p1 >= cnt_w) begin
                        n_rsp.status = ST_NOTFOUND;
                        n_done       = 1'b1;
                    end
                end
            end
            S_DEL_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[AW-1:0];
                mem_wdata = mem_rdata;
                mem_raddr = AW'(k_p2);
                n_k       = CW'(k_p1);
                if (k_p2 >= cnt_w) begin
                    n_count            = r_count - CW'(1);
                    n_rsp.status       = ST_OK;
                    n_rsp.entries_held = 5'(r_count - CW'(1));
                    n_done             = 1'b1;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_k   <= n_k;
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ----- sim/tb.sv -----
// self-checking testbench of the job record list: random and directed commands vs a shadow list
module tb;
    import jrl_pkg::*;

    localparam int unsigned DEPTH = DEPTH_DEF;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int MODE_FILL  = 0;
    localparam int MODE_MIX   = 1;
    localparam int MODE_DRAIN = 2;
    localparam int N_RANDOM   = 1630;
    localparam int PHASE_LEN  = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    job_record_list_insert_search_delete #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    always #10 i_clk = ~i_clk;

    // shadow copy of the list
    t_rec        list_rec [DEPTH];
    int          list_cnt = 0;

    t_req        pending_cmds [$];
    t_rsp        rsp_due [$];
    int          n_queued  = 0;
    int          n_sent    = 0;
    int          n_checked = 0;
    int          errors    = 0;
    int          status_seen [4] = '{0, 0, 0, 0};
    int          peak_cnt  = 0;
    int unsigned idle_left = 0;
    logic        no_idle   = 1'b0;

    function automatic int first_slot_of(logic [7:0] id);
        for (int k = 0; k < list_cnt; k++) begin
            if (list_rec[k].job_id == id) return k;
        end
        return -1;
    endfunction

    // applies one command to the shadow list and returns the result it must give
    function automatic t_rsp predict_list_op(t_req rq);
        t_rsp rs;
        t_rec rec;
        int   slot;
        rs = '0;
        rs.status = ST_OK;
        case (rq.cmd)
            CMD_INSERT: begin
                if (rq.position == 0 || rq.position > list_cnt + 1) begin
                    rs.status = ST_BADPOS;
                end else if (list_cnt >= DEPTH) begin
                    rs.status = ST_FULL;
                end else begin
                    slot = rq.position - 1;
                    for (int k = list_cnt; k > slot; k--) list_rec[k] = list_rec[k - 1];
                    rec.job_id         = rq.job_id;
                    rec.memory_size    = rq.memory_size;
                    rec.arrival_time   = rq.arrival_time;
                    rec.run_time       = rq.run_time;
                    rec.deadline       = rq.deadline;
                    rec.start_time     = rq.start_time;
                    rec.memory_address = rq.memory_address;
                    rec.process_id     = rq.process_id;
                    list_rec[slot] = rec;
                    list_cnt++;
                end
            end
            CMD_SEARCH: begin
                slot = first_slot_of(rq.job_id);
                if (slot < 0) begin
                    rs.status = ST_NOTFOUND;
                end else begin
                    rec = list_rec[slot];
                    rs.found_job_id         = rec.job_id;
                    rs.found_memory_size    = rec.memory_size;
                    rs.found_arrival_time   = rec.arrival_time;
                    rs.found_run_time       = rec.run_time;
                    rs.found_deadline       = rec.deadline;
                    rs.found_start_time     = rec.start_time;
                    rs.found_memory_address = rec.memory_address;
                    rs.found_process_id     = rec.process_id;
                end
            end
            CMD_DELETE: begin
                slot = first_slot_of(rq.job_id);
                if (slot < 0) begin
                    rs.status = ST_NOTFOUND;
                end else begin
                    for (int k = slot; k + 1 < list_cnt; k++) list_rec[k] = list_rec[k + 1];
                    list_cnt--;
                end
            end
            default: ;
        endcase
        rs.entries_held = 5'(list_cnt);
        status_seen[rs.status]++;
        if (list_cnt > peak_cnt) peak_cnt = list_cnt;
        return rs;
    endfunction

    function automatic t_req job_cmd(logic [1:0] c, logic [4:0] p, logic [7:0] id,
                                     logic [15:0] v);
        t_req rq;
        rq.cmd            = c;
        rq.position       = p;
        rq.job_id         = id;
        rq.memory_size    = v[7:0];
        rq.arrival_time   = v;
        rq.run_time       = v;
        rq.deadline       = v;
        rq.start_time     = v;
        rq.memory_address = v;
        rq.process_id     = v[15:8];
        return rq;
    endfunction

    // mostly well-formed commands aimed at the current list contents, some noise
    function automatic t_req random_cmd(int mode);
        t_req rq;
        int   roll;
        int   ins_w;
        int   srch_w;
        rq.cmd            = CMD_INSERT;
        rq.position       = 5'($urandom());
        rq.job_id         = 8'($urandom());
        rq.memory_size    = 8'($urandom());
        rq.arrival_time   = 16'($urandom());
        rq.run_time       = 16'($urandom());
        rq.deadline       = 16'($urandom());
        rq.start_time     = 16'($urandom());
        rq.memory_address = 16'($urandom());
        rq.process_id     = 8'($urandom());
        if ($urandom_range(0, 99) < 8) begin
            rq.cmd = 2'($urandom());
            return rq;
        end
        case (mode)
            MODE_FILL:  begin ins_w = 70; srch_w = 20; end
            MODE_DRAIN: begin ins_w = 15; srch_w = 25; end
            default:    begin ins_w = 40; srch_w = 30; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < ins_w) begin
            rq.cmd = CMD_INSERT;
            if ($urandom_range(0, 9) != 0) rq.position = 5'($urandom_range(1, list_cnt + 1));
            // small id pool so duplicates and first-match cases show up
            if ($urandom_range(0, 3) != 0) rq.job_id = 8'($urandom_range(0, 23));
        end else begin
            rq.cmd = (roll < ins_w + srch_w) ? CMD_SEARCH : CMD_DELETE;
            if (list_cnt > 0 && $urandom_range(0, 4) != 0)
                rq.job_id = list_rec[$urandom_range(0, list_cnt - 1)].job_id;
        end
        return rq;
    endfunction

    task automatic check_field(string fname, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
            errors++;
        end
    endtask

    // driver: one transfer per start && !busy edge, random idle between items
    always @(posedge i_clk) begin
        logic line_free;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            line_free = !start;
            if (start && !busy) begin
                rsp_due.push_back(predict_list_op(i_req));
                n_sent++;
                line_free = 1'b1;
                idle_left = no_idle ? 0 : $urandom_range(0, 13);
            end
            if (line_free) begin
                if (idle_left != 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    i_req <= pending_cmds.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_done) begin
            if (rsp_due.size() == 0) begin
                $error("result with no command outstanding");
                errors++;
            end else begin
                exp_rsp = rsp_due.pop_front();
                check_field("status", exp_rsp.status, o_rsp.status);
                check_field("found_job_id", exp_rsp.found_job_id, o_rsp.found_job_id);
                check_field("found_memory_size", exp_rsp.found_memory_size,
                            o_rsp.found_memory_size);
                check_field("found_arrival_time", exp_rsp.found_arrival_time,
                            o_rsp.found_arrival_time);
                check_field("found_run_time", exp_rsp.found_run_time, o_rsp.found_run_time);
                check_field("found_deadline", exp_rsp.found_deadline, o_rsp.found_deadline);
                check_field("found_start_time", exp_rsp.found_start_time,
                            o_rsp.found_start_time);
                check_field("found_memory_address", exp_rsp.found_memory_address,
                            o_rsp.found_memory_address);
                check_field("found_process_id", exp_rsp.found_process_id,
                            o_rsp.found_process_id);
                check_field("entries_held", exp_rsp.entries_held, o_rsp.entries_held);
                n_checked++;
            end
        end
    end

    initial begin
        t_req directed [$];
        int   mode;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list, error codes, extremes, duplicates and first-match
        directed.push_back(job_cmd(CMD_UNUSED, 5'd31, 8'hFF, 16'hFFFF));
        directed.push_back(job_cmd(CMD_SEARCH, 5'd0, 8'h00, 16'h0000));
        directed.push_back(job_cmd(CMD_DELETE, 5'd0, 8'hFF, 16'h0000));
        directed.push_back(job_cmd(CMD_INSERT, 5'd0, 8'h11, 16'h1234));
        directed.push_back(job_cmd(CMD_INSERT, 5'd2, 8'h11, 16'h1234));
        directed.push_back(job_cmd(CMD_INSERT, 5'd1, 8'hFF, 16'hFFFF));
        directed.push_back(job_cmd(CMD_INSERT, 5'd2, 8'h00, 16'h0000));
        directed.push_back(job_cmd(CMD_INSERT, 5'd1, 8'h07, 16'hA5C3));
        directed.push_back(job_cmd(CMD_INSERT, 5'd2, 8'h07, 16'h5A3C));
        directed.push_back(job_cmd(CMD_SEARCH, 5'd0, 8'h07, 16'h0000));
        directed.push_back(job_cmd(CMD_SEARCH, 5'd31, 8'hFF, 16'hFFFF));
        directed.push_back(job_cmd(CMD_SEARCH, 5'd0, 8'h00, 16'h0000));
        directed.push_back(job_cmd(CMD_INSERT, 5'd31, 8'h22, 16'hFFFF));
        directed.push_back(job_cmd(CMD_INSERT, 5'd6, 8'h22, 16'h0F0F));
        directed.push_back(job_cmd(CMD_DELETE, 5'd0, 8'h07, 16'h0000));
        directed.push_back(job_cmd(CMD_SEARCH, 5'd0, 8'h07, 16'h0000));
        directed.push_back(job_cmd(CMD_DELETE, 5'd0, 8'h00, 16'h0000));
        directed.push_back(job_cmd(CMD_DELETE, 5'd0, 8'h07, 16'h0000));
        directed.push_back(job_cmd(CMD_UNUSED, 5'd1, 8'h07, 16'h5555));
        directed.push_back(job_cmd(CMD_DELETE, 5'd0, 8'hFF, 16'h0000));
        directed.push_back(job_cmd(CMD_SEARCH, 5'd0, 8'hFF, 16'h0000));
        foreach (directed[k]) begin
            pending_cmds.push_back(directed[k]);
            n_queued++;
        end

        mode = MODE_FILL;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % PHASE_LEN == 0 && n != 0) begin
                mode = (mode == MODE_FILL) ? MODE_MIX :
                       (mode == MODE_MIX) ? MODE_DRAIN : MODE_FILL;
                no_idle = ($urandom_range(0, 3) == 0);
            end
            // keep the queue short so commands track the current list contents
            while (pending_cmds.size() >= 4) @(posedge i_clk);
            pending_cmds.push_back(random_cmd(mode));
            n_queued++;
        end

        while (n_sent < n_queued) @(posedge i_clk);
        while (rsp_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d commands transferred, %0d results checked, peak list size %0d",
                 n_sent, n_checked, peak_cnt);
        $display("status mix: ok %0d, bad position %0d, full %0d, not found %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(40_000_000);
        $display("timeout waiting for the list to finish");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/jrl_pkg.sv
design/jrl_mem.sv
design/job_record_list_insert_search_delete.sv
sim/tb.sv
